// ===== rtl/core/dctd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_pkg: shared widths and constants for the direct-form DCT-II
// Word widths of the sample and coefficient channels, the accumulator and
// product widths, and the constants used to build the cosine wave.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COS_W    = 16;
  localparam int PROD_W   = SAMPLE_W + COS_W;
  localparam int COEF_W   = 23;
  // Q1.15 rounding drops fifteen bits, so the accumulator carries them on top.
  localparam int FRAC_W   = 15;
  localparam int ACC_W    = COEF_W + FRAC_W;

  // pi in Q2.62 and unity in Q30 for the elaboration-time cosine series.
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

  localparam int TAYLOR_TERMS = 10;
  // Divisors (2i-1)*2i of the cosine series, for i = 1 upwards.
  localparam logic [8:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380
  };

endpackage
`default_nettype wire

// ===== rtl/core/dct_ii_direct.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dct_ii_direct: unnormalised DCT-II in direct form
// Gathers BLOCK_LENGTH samples in a memory, then forms every coefficient
// with one shared multiply-accumulate unit and a constant cosine wave.
// ----------------------------------------------------------------------------
// Usage. Samples arrive as words on the sample channel (sample_valid,
// sample_ready), in order n = 0..N-1, N = BLOCK_LENGTH. Each accepted word is
// written into the sample memory. Accepting the Nth word starts a block: the
// block then stops taking samples and sends N coefficient words, k = 0..N-1,
// on the coefficient channel, with last_coefficient high on k = N-1.
// Schedule. One coefficient needs N reads of the sample memory
// through the single multiply-accumulate unit; then the read, multiply and
// accumulate stages drain and the sum is loaded into the output register.
// Coefficients are formed one after another, and no samples of the next
// block are taken until the last coefficient reaches the output register.
// The single memory read port limits the throughput.
// Reset. A synchronous active-high reset returns the block to loading at
// position zero with an empty pipeline and no coefficient pending; the
// sample memory itself is not cleared, as each block overwrites it.
// Stalls. If the receiver holds coefficient_ready low, the finished sum waits
// in the accumulator until the output register frees up; nothing is lost.
// Once the last coefficient is in the output register, samples of the next
// block are accepted again, even while that word still waits to be taken.
// ----------------------------------------------------------------------------
module dct_ii_direct #(
  parameter int BLOCK_LENGTH = 64
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   sample_valid,
  output logic                                  sample_ready,
  input  wire  logic signed [dctd_pkg::SAMPLE_W-1:0] sample,
  output logic                                  coefficient_valid,
  input  wire                                   coefficient_ready,
  output logic signed [dctd_pkg::COEF_W-1:0]    coefficient,
  output logic                                  last_coefficient
);

  localparam int CNT_W  = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
  localparam int WAVE_N = 4 * BLOCK_LENGTH;
  localparam int IDX_W  = $clog2(WAVE_N);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BLOCK_LENGTH - 1);
  localparam logic [IDX_W:0]   WAVE_LEN = (IDX_W + 1)'(WAVE_N);

  // Angle step pi/(2N) in Q2.62, worked out at elaboration.
  localparam logic [63:0] ANGLE_STEP = dctd_pkg::PI_Q62 / 64'(2 * BLOCK_LENGTH);

  typedef logic signed [dctd_pkg::COS_W-1:0] wave_t [WAVE_N];

  // Quarter-wave cosine in Q1.15 by a fixed-point Taylor series.
  function automatic logic [14:0] quarter_cos(input logic [63:0] j);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] s;
    int                 i;
    a    = (ANGLE_STEP * j + 64'h8000_0000) >> 32;
    a2   = (a * a + 64'h2000_0000) >> 30;
    term = dctd_pkg::ONE_Q30;
    s    = signed'(dctd_pkg::ONE_Q30);
    for (i = 1; i <= dctd_pkg::TAYLOR_TERMS; i++) begin
      term = ((term * a2) >> 30) / 64'(dctd_pkg::TAYLOR_DIV[i-1]);
      if (i[0]) begin
        s = s - signed'(term);
      end else begin
        s = s + signed'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    return s[14:0];
  endfunction

  // Full wave over 4N points, unfolded from the quarter wave by symmetry.
  function automatic wave_t build_wave();
    wave_t       w;
    logic [14:0] q [BLOCK_LENGTH+1];
    int          j;
    int          m;
    for (j = 0; j <= BLOCK_LENGTH; j++) begin
      q[j] = quarter_cos(64'(j));
    end
    for (m = 0; m < WAVE_N; m++) begin
      if (m <= BLOCK_LENGTH) begin
        w[m] = signed'({1'b0, q[m]});
      end else if (m < 2 * BLOCK_LENGTH) begin
        w[m] = -signed'({1'b0, q[2 * BLOCK_LENGTH - m]});
      end else if (m <= 3 * BLOCK_LENGTH) begin
        w[m] = -signed'({1'b0, q[m - 2 * BLOCK_LENGTH]});
      end else begin
        w[m] = signed'({1'b0, q[WAVE_N - m]});
      end
    end
    return w;
  endfunction

  localparam wave_t COS_WAVE = build_wave();

  // Sequencer states.
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] k_idx;
  logic [CNT_W-1:0] n_idx;
  logic [IDX_W-1:0] m_idx;

  // The sample memory: one write port while loading, one read port while
  // issuing, read data registered.
  logic [dctd_pkg::SAMPLE_W-1:0] store [BLOCK_LENGTH];

  logic signed [dctd_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [dctd_pkg::COS_W-1:0]    cos_q;
  logic signed [dctd_pkg::PROD_W-1:0]   prod;
  logic signed [dctd_pkg::ACC_W-1:0]    acc;
  logic                                 s1_valid;
  logic                                 s2_valid;

  logic                              sample_take;
  logic                              pipe_empty;
  logic                              out_free;
  logic                              coef_load;
  logic [IDX_W:0]                    m_sum;
  logic [IDX_W-1:0]                  m_next;
  logic signed [dctd_pkg::ACC_W-1:0] biased;

  assign sample_ready = (state == ST_LOAD);
  assign sample_take  = sample_valid && sample_ready;
  assign pipe_empty   = !s1_valid && !s2_valid;
  assign out_free     = !coefficient_valid || coefficient_ready;
  // A finished sum moves into the output register in this cycle.
  assign coef_load    = (state == ST_DRAIN) && pipe_empty && out_free;

  // Cosine index (2n+1)k mod 4N advances by 2k for each n; one wrap at most.
  assign m_sum  = {1'b0, m_idx} + (IDX_W + 1)'({k_idx, 1'b0});
  assign m_next = (m_sum >= WAVE_LEN) ? IDX_W'(m_sum - WAVE_LEN) : m_sum[IDX_W-1:0];

  // Round half up to Q1.15 scale: add half an LSB, then drop the fraction.
  assign biased = acc + dctd_pkg::ACC_W'(1 << (dctd_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (sample_take) begin
      store[load_count] <= sample;
    end
    rd_data <= signed'(store[n_idx]);
    cos_q   <= COS_WAVE[m_idx];
    prod    <= rd_data * cos_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_LOAD;
      load_count        <= '0;
      k_idx             <= '0;
      n_idx             <= '0;
      m_idx             <= '0;
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      acc               <= '0;
      coefficient_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_ISSUE);
      s2_valid <= s1_valid;
      if (s2_valid) begin
        acc <= acc + {{(dctd_pkg::ACC_W - dctd_pkg::PROD_W){prod[dctd_pkg::PROD_W-1]}}, prod};
      end
      if (coef_load) begin
        coefficient_valid <= 1'b1;
      end else if (coefficient_valid && coefficient_ready) begin
        coefficient_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (sample_take) begin
            if (load_count == LAST_POS) begin
              load_count <= '0;
              k_idx      <= '0;
              n_idx      <= '0;
              m_idx      <= '0;
              acc        <= '0;
              state      <= ST_ISSUE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          n_idx <= n_idx + 1'b1;
          m_idx <= m_next;
          if (n_idx == LAST_POS) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The sum is complete once the pipeline is empty; it waits here
          // until the output register can take it.
          if (coef_load) begin
            coefficient       <= biased[dctd_pkg::ACC_W-1:dctd_pkg::FRAC_W];
            last_coefficient  <= (k_idx == LAST_POS);
            acc               <= '0;
            n_idx             <= '0;
            if (k_idx == LAST_POS) begin
              state <= ST_LOAD;
            end else begin
              k_idx <= k_idx + 1'b1;
              m_idx <= IDX_W'(k_idx + 1'b1);
              state <= ST_ISSUE;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // While samples are being loaded no product is in flight.
  a_load_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (!s1_valid && !s2_valid))
    else $error("pipeline busy while loading samples");

  // A partly filled block only exists in the load state.
  a_count_in_load: assert property (@(posedge clk) disable iff (rst)
    (load_count != '0) |-> (state == ST_LOAD))
    else $error("load position held outside the load state");

  // The cosine index never leaves the wave.
  a_wave_index: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, m_idx} < WAVE_LEN))
    else $error("cosine index beyond the wave");

  // A new coefficient is only loaded when the previous word has gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (coefficient_valid && !coefficient_ready) |=> $stable(coefficient) && coefficient_valid)
    else $error("pending coefficient overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/dct_ii_direct_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dct_ii_direct_test: self-checking bench for the direct-form DCT-II
// Feeds blocks of signed Q1.15 sample words and checks every coefficient word
// against a bit-exact integer model of the transform, kept in the bench.
// ----------------------------------------------------------------------------
module dct_ii_direct_test;

  localparam int N = 64;
  // Time allowance per coefficient, used to size the final wait.
  localparam int COEF_CYCLES = N + 3;

  // pi in Q2.62, the starting point of the cosine series.
  localparam longint unsigned PI_FIXED   = 64'hC90F_DAA2_2168_C235;
  localparam longint unsigned UNITY_Q30  = 64'h0000_0000_4000_0000;
  localparam int              SERIES_LEN = 10;

  typedef struct {
    logic signed [dctd_pkg::COEF_W-1:0] value;
    logic                               last;
  } coef_word_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 sample_valid = 1'b0;
  logic                                 sample_ready;
  logic signed [dctd_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                 coefficient_valid;
  logic                                 coefficient_ready = 1'b0;
  logic signed [dctd_pkg::COEF_W-1:0]   coefficient;
  logic                                 last_coefficient;

  // Model state: the quarter cosine wave, the sample memory and the write
  // position within the current block.
  int                                   cos_quarter [0:N];
  logic signed [dctd_pkg::SAMPLE_W-1:0] sample_mem [N];
  int                                   load_pos = 0;

  // Coefficient words still owed by the block, oldest first.
  coef_word_t                 awaited_coefs [$];

  int                         error_count = 0;
  // When set, the sender inserts no gaps and the receiver starts no new holds.
  bit                         no_idle = 1'b0;
  int                         hold_left = 0;

  dct_ii_direct #(
    .BLOCK_LENGTH(N)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .sample           (sample),
    .coefficient_valid(coefficient_valid),
    .coefficient_ready(coefficient_ready),
    .coefficient      (coefficient),
    .last_coefficient (last_coefficient)
  );

  always #10 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(16, 4);
    return $urandom_range(200, 40);
  endfunction

  // Quarter-wave cosine in Q1.15 for angle pi*j/(2N), from a ten-term
  // Taylor series carried out in Q30 with integer arithmetic only.
  function automatic int quarter_cos(input longint unsigned j);
    longint unsigned step, angle, angle_sq, term;
    longint          s;
    step     = PI_FIXED / longint'(2 * N);
    angle    = (step * j + 64'h8000_0000) >> 32;
    angle_sq = (angle * angle + 64'h2000_0000) >> 30;
    term     = UNITY_Q30;
    s        = longint'(UNITY_Q30);
    for (int i = 1; i <= SERIES_LEN; i++) begin
      term = ((term * angle_sq) >> 30) / longint'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) s -= longint'(term);
      else            s += longint'(term);
    end
    if (s < 0) s = 0;
    s = (s + 64'sd16384) >>> 15;
    if (s > 32767) s = 32767;
    return int'(s);
  endfunction

  // Full cosine wave over 4N points, folded onto the quarter wave.
  function automatic int cos_at(input int m);
    m = m % (4 * N);
    if (m <= N)     return cos_quarter[m];
    if (m < 2 * N)  return -cos_quarter[2 * N - m];
    if (m <= 3 * N) return -cos_quarter[m - 2 * N];
    return cos_quarter[4 * N - m];
  endfunction

  // Forms all N coefficients of the block held in sample_mem. Products are
  // summed exactly, then the sum is rounded half-up to Q1.15 scale.
  task automatic transform_block();
    longint     acc;
    longint     rounded;
    coef_word_t word;
    for (int k = 0; k < N; k++) begin
      acc = 0;
      for (int n = 0; n < N; n++)
        acc += longint'(sample_mem[n]) * longint'(cos_at((2 * n + 1) * k));
      rounded    = (acc + 64'sd16384) >>> 15;
      word.value = rounded[dctd_pkg::COEF_W-1:0];
      word.last  = (k == N - 1);
      awaited_coefs.push_back(word);
    end
  endtask

  // Offers one sample word and waits for it to be taken. The task is entered
  // and left at a falling edge; valid stays high between back-to-back words.
  task automatic push_sample(input logic signed [dctd_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (!sample_ready);
    // The word is in: mirror it in the model, closing the block at N-1.
    sample_mem[load_pos] = value;
    if (load_pos == N - 1) begin
      load_pos = 0;
      transform_block();
    end else begin
      load_pos++;
    end
    @(negedge clk);
  endtask

  // Holds off the sender until every owed coefficient word has come back.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (awaited_coefs.size() != 0) @(negedge clk);
  endtask

  // One block of hand-picked words: the field extremes, zero and unit
  // values, alternating full-scale signs, checkerboard bit patterns and a ramp.
  // The block is not drained, so the next words meet its coefficients.
  task automatic test_edge_patterns();
    logic signed [dctd_pkg::SAMPLE_W-1:0] v;
    for (int n = 0; n < N; n++) begin
      case (n)
        0:       v = 16'sd32767;
        1:       v = -16'sd32768;
        2:       v = 16'sd0;
        3:       v = -16'sd1;
        4:       v = 16'sd1;
        default: begin
          if (n < 32)      v = (n % 2) ? 16'sd32767 : -16'sd32768;
          else if (n < 48) v = (n % 2) ? 16'h5555 : 16'hAAAA;
          else             v = 16'(n * 1021 - 30000);
        end
      endcase
      push_sample(v);
    end
  endtask

  // A random block sent straight after the previous one, so that its first
  // samples meet a last coefficient that may still be waiting. For a stretch
  // the sender adds no gaps and the receiver starts no new holds, then the
  // sender waits for every owed word.
  task automatic test_random_blocks();
    logic signed [dctd_pkg::SAMPLE_W-1:0] v;
    for (int n = 0; n < N; n++) begin
      no_idle = (n >= 16 && n < 48);
      case ($urandom_range(3))
        0:       v = 16'($urandom_range(16, 0)) - 16'sd8;
        1: begin
          case ($urandom_range(3))
            0:       v = -16'sd32768;
            1:       v = 16'sd32767;
            2:       v = -16'sd1;
            default: v = 16'sd0;
          endcase
        end
        default: v = 16'($urandom_range(16'hFFFF, 0));
      endcase
      push_sample(v);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // A few samples that leave a block unfinished: no word may come out.
  task automatic test_partial_block();
    for (int n = 0; n < 6; n++) push_sample(16'($urandom_range(16'hFFFF, 0)));
    sample_valid <= 1'b0;
  endtask

  // Receiver side: ready is dropped for random spells; no new spell starts
  // while the no-gap stretch is running.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      coefficient_ready <= 1'b0;
      hold_left--;
    end else begin
      coefficient_ready <= 1'b1;
      if (!no_idle && $urandom_range(3) == 0) hold_left = pick_gap();
    end
  end

  // Every coefficient word taken is matched against the oldest one owed.
  always @(posedge clk) begin
    coef_word_t owed;
    if (!rst && coefficient_valid && coefficient_ready) begin
      if (awaited_coefs.size() == 0) begin
        $display("%0t: unexpected coefficient word %0d (last %0b)",
                 $time, coefficient, last_coefficient);
        error_count++;
      end else begin
        owed = awaited_coefs.pop_front();
        if (coefficient !== owed.value) begin
          $display("%0t: coefficient expected %0d, got %0d",
                   $time, owed.value, coefficient);
          error_count++;
        end
        if (last_coefficient !== owed.last) begin
          $display("%0t: last_coefficient expected %0b, got %0b",
                   $time, owed.last, last_coefficient);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int j = 0; j <= N; j++) cos_quarter[j] = quarter_cos(longint'(j));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_patterns();
    test_random_blocks();
    test_partial_block();

    // Let any stray word surface before the verdict.
    wait_drained();
    repeat (2 * COEF_CYCLES) @(negedge clk);
    if (awaited_coefs.size() != 0) begin
      $display("%0t: %0d coefficient words never arrived", $time, awaited_coefs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[dct_ii_direct] OK");
    end else begin
      $display("[dct_ii_direct] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("[dct_ii_direct] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/dctd_pkg.sv
rtl/core/dct_ii_direct.sv
tb/dct_ii_direct_test.sv
